// File: src/value_to_spike_rate_encoder_defines.svh
// Assertion macros shared by the encoder RTL
`ifndef VALUE_TO_SPIKE_RATE_ENCODER_DEFINES_SVH
`define VALUE_TO_SPIKE_RATE_ENCODER_DEFINES_SVH
// Property holds at every clock edge outside reset
`define VSRE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// Implication checked on the next edge
`define VSRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: src/vsre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsre_pkg
// Shared types and constants of the spike rate encoder.
// ----------------------------------------------------------------------------
package vsre_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam logic [CfgIdxW-1:0] REG_MIN = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LIFE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PERIOD = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BINARY = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_UNITS = 3'd5;
	localparam logic [31:0] AGE_EXPIRED = 32'hFFFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item and span
		logic div_start; // start code division
		logic div_step;  // one quotient bit
		logic select;    // final code, clamped at the range ends
		logic unit_start;// clear unit index
		logic unit_step; // process one unit
		logic mod_step;  // one modulo restoring step
		logic unit_done; // write back current unit
		logic emit;      // move finished mask into the output register
	} vsre_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
		logic mod_last;
		logic unit_last;
	} vsre_sts_t;
endpackage

// File: src/vsre_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsre_datapath
// Registers, code divider and per-unit age/event update, one unit at a time.
// ----------------------------------------------------------------------------
module vsre_datapath #(
	parameter int unsigned MAX_UNITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [vsre_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [vsre_pkg::CfgDataW-1:0] cfg_data,
	input  logic [19:0]                 time_step_us,
	input  logic                        has_sample,
	input  logic signed [31:0]          sample,
	input  vsre_pkg::vsre_cmd_t         cmd,
	output vsre_pkg::vsre_sts_t         sts,
	output logic [15:0]                 mask
);
	import vsre_pkg::*;
	localparam int unsigned UW = $clog2(MAX_UNITS);
	localparam int unsigned NW = $clog2(MAX_UNITS + 1);

	logic signed [31:0] min_q, max_q;
	logic [31:0] life_q;
	logic [19:0] period_cfg_q;
	logic binary_q;
	logic [4:0] units_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= 32'sd65535;
			life_q <= 32'd1000000;
			period_cfg_q <= 20'd10000;
			binary_q <= 1'b0;
			units_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN: min_q <= cfg_data;
				REG_MAX: max_q <= cfg_data;
				REG_LIFE: life_q <= cfg_data;
				REG_PERIOD: period_cfg_q <= cfg_data[19:0];
				REG_BINARY: binary_q <= cfg_data[0];
				REG_UNITS: units_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// active unit count
	logic [NW-1:0] n_act;
	always_comb begin
		logic [6:0] n;
		n = {2'b0, units_q};
		if (n == 7'd0) n = 7'd1;
		if (n > 7'(MAX_UNITS)) n = 7'(MAX_UNITS);
		if (binary_q && n > 7'd8) n = 7'd8;
		n_act = NW'(n);
	end

	logic [19:0] period;
	assign period = (period_cfg_q == 20'd0) ? 20'd1 : period_cfg_q;

	// input item capture
	logic [19:0] step_q;
	logic has_q;
	logic signed [31:0] samp_q;
	logic [32:0] span_q;
	logic [7:0] k_q;
	logic sel_hi_q, sel_lo_q;

	// code divider: (off*2K + span) / (2*span), restoring, 43-bit numerator
	localparam int unsigned DNW = 43;
	logic [DNW-1:0] num_q;
	logic [34:0] rem_q;
	logic [5:0] dcnt_q;
	logic [7:0] code_q;

	logic [32:0] span_c, off_c;
	assign span_c = 33'(signed'(max_q)) - 33'(signed'(min_q));
	assign off_c = 33'(signed'(samp_q)) - 33'(signed'(min_q));

	logic [34:0] rem_sh, rem_sub;
	assign rem_sh = {rem_q[33:0], num_q[DNW-1]};
	assign rem_sub = rem_sh - {1'b0, span_q, 1'b0};
	assign sts.div_last = (dcnt_q == 6'd0);

	// update ages live in flip-flops per unit, walked by index
	logic [31:0] uage_q [MAX_UNITS];
	logic [19:0] eage_q [MAX_UNITS];
	logic [MAX_UNITS-1:0] primed_q;
	logic [UW-1:0] idx_q;
	logic [20:0] acc_q;
	logic [40:0] pstep_q;
	logic [4:0] mcnt_q;
	logic [15:0] mask_q;

	logic [31:0] ua_cur;
	logic live_cur;
	assign ua_cur = uage_q[idx_q];
	assign live_cur = (ua_cur != AGE_EXPIRED) && (ua_cur <= life_q);
	assign sts.unit_last = (NW'(idx_q) == n_act - NW'(1));
	assign sts.mod_last = (mcnt_q == 5'd0);

	logic [32:0] ua_sum;
	assign ua_sum = {1'b0, ua_cur} + 33'(step_q);

	// select hit per unit index
	function automatic logic sel_hit(input logic [UW-1:0] i, input logic bin,
		input logic [7:0] c, input logic [NW-1:0] n);
		logic h;
		if (bin) h = (32'(i) < 32'd8) ? c[3'(i)] : 1'b0;
		else h = (32'(c) < 32'(n)) && (32'(c) == 32'(i));
		return h;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_UNITS; i++) begin
				uage_q[i] <= AGE_EXPIRED;
				eage_q[i] <= '0;
			end
			primed_q <= '1;
			mask <= '0;
			mask_q <= '0;
			step_q <= '0;
			has_q <= 1'b0;
			samp_q <= '0;
			span_q <= '0;
			k_q <= '0;
			sel_hi_q <= 1'b0;
			sel_lo_q <= 1'b0;
			num_q <= '0;
			rem_q <= '0;
			dcnt_q <= '0;
			code_q <= '0;
			idx_q <= '0;
			acc_q <= '0;
			pstep_q <= '0;
			mcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				step_q <= time_step_us;
				has_q <= has_sample;
				samp_q <= sample;
				span_q <= span_c;
			end
			if (cmd.div_start) begin
				k_q <= binary_q ? 8'((9'd1 << n_act) - 9'd1) : 8'(n_act - NW'(1));
				sel_hi_q <= samp_q >= max_q;
				sel_lo_q <= samp_q <= min_q;
				num_q <= DNW'((off_c * (binary_q ? 10'((10'd1 << n_act) - 10'd1)
					: 10'(n_act - NW'(1)))) << 1) + DNW'(span_q);
				rem_q <= '0;
				dcnt_q <= 6'(DNW - 1);
				code_q <= '0;
			end
			if (cmd.div_step) begin
				num_q <= {num_q[DNW-2:0], 1'b0};
				dcnt_q <= dcnt_q - 6'd1;
				if (!rem_sub[34]) begin
					rem_q <= rem_sub;
					code_q <= {code_q[6:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					code_q <= {code_q[6:0], 1'b0};
				end
			end
			if (cmd.select) begin
				logic [7:0] c;
				c = sel_hi_q ? k_q : (sel_lo_q ? 8'd0 : code_q);
				code_q <= c;
			end
			if (cmd.unit_start) begin
				idx_q <= '0;
				mask_q <= '0;
			end
			// age advance, selection, and load accumulator for this unit
			if (cmd.unit_step) begin
				logic [31:0] na;
				logic l2;
				logic [20:0] acc_n;
				na = ua_cur;
				if (live_cur) na = ua_sum[32] ? AGE_EXPIRED : ua_sum[31:0];
				if (has_q && sel_hit(idx_q, binary_q, code_q, n_act)) na = '0;
				uage_q[idx_q] <= na;
				l2 = (na != AGE_EXPIRED) && (na <= life_q);
				acc_n = (primed_q[idx_q] ? {1'b0, period} : {1'b0, eage_q[idx_q]})
					+ 21'(step_q);
				acc_q <= acc_n;
				if (l2) begin
					primed_q[idx_q] <= 1'b0;
					if (acc_n >= {1'b0, period} && 32'(idx_q) < 32'd16)
						mask_q[4'(idx_q)] <= 1'b1;
				end
				pstep_q <= {21'd0, period} << 20;
				mcnt_q <= 5'd20;
			end
			// restoring modulo: subtract period << k for k = 20 down to 0;
			// acc stays below 2^21, so the remainder ends below the period
			if (cmd.mod_step) begin
				if ({20'd0, acc_q} >= pstep_q) acc_q <= acc_q - pstep_q[20:0];
				pstep_q <= pstep_q >> 1;
				mcnt_q <= mcnt_q - 5'd1;
			end
			if (cmd.unit_done) begin
				if ((ua_cur != AGE_EXPIRED) && (ua_cur <= life_q))
					eage_q[idx_q] <= acc_q[19:0];
				idx_q <= idx_q + UW'(1);
			end
			// finished mask into the output register
			if (cmd.emit) mask <= mask_q;
		end
	end
endmodule

// File: src/vsre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsre_ctrl
// Sequencer: capture, divide, select, walk units, present result.
// ----------------------------------------------------------------------------
module vsre_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  vsre_pkg::vsre_sts_t sts,
	output vsre_pkg::vsre_cmd_t cmd
);
	import vsre_pkg::*;
	typedef enum logic [2:0] {
		S_IDLE, S_DSTART, S_DIV, S_SEL, S_UNIT, S_MOD, S_DONE, S_OUT
	} state_t;
	state_t state_q;
	logic busy_q;
	logic emit;

	assign in_ready = !busy_q;
	// output register free or being read this cycle
	assign emit = (state_q == S_OUT) && (!out_valid || out_ready);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.div_start = (state_q == S_DSTART);
		cmd.div_step = (state_q == S_DIV);
		cmd.select = (state_q == S_SEL);
		cmd.unit_start = (state_q == S_SEL);
		cmd.unit_step = (state_q == S_UNIT);
		cmd.mod_step = (state_q == S_MOD);
		cmd.unit_done = (state_q == S_DONE);
		cmd.emit = emit;
	end

	// state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (emit) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					state_q <= S_DSTART;
					busy_q <= 1'b1;
				end
				S_DSTART: state_q <= S_DIV;
				S_DIV: if (sts.div_last) state_q <= S_SEL;
				S_SEL: state_q <= S_UNIT;
				S_UNIT: state_q <= S_MOD;
				S_MOD: if (sts.mod_last) state_q <= S_DONE;
				S_DONE: begin
					if (sts.unit_last) state_q <= S_OUT;
					else state_q <= S_UNIT;
				end
				S_OUT: if (emit) begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/value_to_spike_rate_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_to_spike_rate_encoder
// Rate coded spike encoder with serial code divider and unit walk.
// ----------------------------------------------------------------------------
// channel  | signals                                  | transfer
// in       | in_valid/in_ready, time_step_us,has_sample,sample | valid & ready
// out      | out_valid/out_ready, spike_mask          | valid & ready
// cfg      | cfg_we, cfg_index, cfg_data              | cfg_we
// A tick runs from its input transfer to its result (N active units) through a setup
// step, the restoring divider, a select step, then per unit an update, the modulo
// steps and a write-back, and last the output step.
// in_ready is low for the whole tick; the next transfer can follow right after emit.
// Reset clears all unit state at once; registers take their reset values.
// A finished tick waits in its output cycle while the previous result is unread.
module value_to_spike_rate_encoder #(
	parameter int unsigned MAX_UNITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vsre_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [vsre_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [19:0]                  time_step_us,
	input  logic                         has_sample,
	input  logic signed [31:0]           sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [15:0]                  spike_mask
);
	import vsre_pkg::*;
	`include "value_to_spike_rate_encoder_defines.svh"
	vsre_cmd_t cmd;
	vsre_sts_t sts;

	vsre_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd);
	vsre_datapath #(.MAX_UNITS(MAX_UNITS)) u_dp (.clk, .arst_n, .cfg_we, .cfg_index,
		.cfg_data, .time_step_us, .has_sample, .sample, .cmd, .sts, .mask(spike_mask));

	`VSRE_ASSERT(a_no_accept_busy, clk, arst_n, !(in_ready && cmd.div_step), "accept while busy")
	`VSRE_ASSERT_NEXT(a_mask_hold, clk, arst_n, out_valid && !out_ready, $stable(spike_mask), "mask moved")
	`VSRE_ASSERT_NEXT(a_load_seq, clk, arst_n, cmd.load, cmd.div_start, "no divide after load")
endmodule
